// ----- rtl/core/uvs_pkg.sv -----
// shared constants, types and arithmetic helpers for the uv sphere vertex generator
package uvs_pkg;

   localparam int ANGLE_BITS_DEF = 16;
   localparam int MAX_BANDS      = 256;
   localparam int IDX_W          = 9;
   localparam int RADIUS_W       = 16;
   localparam int POS_W          = 17;
   localparam int NORM_W         = 16;
   localparam int TEX_W          = 17;
   localparam int CORNER_W       = 17;
   localparam int Q30_W          = 30;
   localparam int SC_W           = 32;
   localparam int MAG_W          = 16;
   localparam int CSR_IDX_W      = 2;
   localparam int CSR_DATA_W     = 16;
   localparam int DEN_W          = IDX_W + 1;

   localparam logic [31:0] PI_Q30 = 32'd3373259426;

   // reset values of the registers
   localparam logic [RADIUS_W-1:0] RADIUS_RST = 16'd256;
   localparam logic [IDX_W-1:0]    BANDS_RST  = 9'd16;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RADIUS    = 2'd0,
      CSR_LAT_BANDS = 2'd1,
      CSR_LON_BANDS = 2'd2
   } csr_index_type;

   // reciprocals for exact truncating division of a q30 value by a constant:
   // shift is 30 plus the bit length of the divisor, reciprocal rounded up
   localparam int S6  = 33;
   localparam int S24 = 35;
   localparam int S120 = 37;
   localparam int S720 = 40;
   localparam int S5040 = 43;
   localparam int S40320 = 46;
   localparam int S362880 = 49;
   localparam int S3628800 = 52;
   localparam logic [30:0] R6       = 31'(((64'd1 << S6) + 64'd5) / 64'd6);
   localparam logic [30:0] R24      = 31'(((64'd1 << S24) + 64'd23) / 64'd24);
   localparam logic [30:0] R120     = 31'(((64'd1 << S120) + 64'd119) / 64'd120);
   localparam logic [30:0] R720     = 31'(((64'd1 << S720) + 64'd719) / 64'd720);
   localparam logic [30:0] R5040    = 31'(((64'd1 << S5040) + 64'd5039) / 64'd5040);
   localparam logic [30:0] R40320   = 31'(((64'd1 << S40320) + 64'd40319) / 64'd40320);
   localparam logic [30:0] R362880  = 31'(((64'd1 << S362880) + 64'd362879) / 64'd362880);
   localparam logic [30:0] R3628800 =
      31'(((64'd1 << S3628800) + 64'd3628799) / 64'd3628800);

   typedef struct packed {
      logic signed [SC_W-1:0] s;
      logic signed [SC_W-1:0] c;
   } sincos_type;

   typedef struct packed {
      logic signed [POS_W-1:0]  pos_x;
      logic signed [POS_W-1:0]  pos_y;
      logic signed [POS_W-1:0]  pos_z;
      logic signed [NORM_W-1:0] norm_x;
      logic signed [NORM_W-1:0] norm_y;
      logic signed [NORM_W-1:0] norm_z;
   } vertex_type;

   // q30 product, truncated
   function automatic logic [Q30_W-1:0] qmul(input logic [Q30_W-1:0] a,
                                             input logic [Q30_W-1:0] b);
      logic [2*Q30_W-1:0] p;
      p = (2*Q30_W)'(a) * (2*Q30_W)'(b);
      return p[2*Q30_W-1:Q30_W];
   endfunction

   // q30 value over a constant by reciprocal multiply
   function automatic logic [Q30_W-1:0] div_recip(input logic [Q30_W-1:0] v,
                                                  input logic [30:0] r,
                                                  input int unsigned s);
      logic [Q30_W+30:0] p;
      p = (Q30_W+31)'(v) * (Q30_W+31)'(r);
      return Q30_W'(p >> s);
   endfunction

endpackage

// ----- rtl/core/uvs_req_if.sv -----
// input channel carrying one grid point
interface uvs_req_if;
   logic                     valid;
   logic                     ready;
   logic [uvs_pkg::IDX_W-1:0] lat_index;
   logic [uvs_pkg::IDX_W-1:0] lon_index;

   modport source (output valid, lat_index, lon_index, input ready);
   modport sink   (input valid, lat_index, lon_index, output ready);
endinterface

// ----- rtl/core/uvs_rsp_if.sv -----
// result channel carrying one vertex
interface uvs_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [uvs_pkg::POS_W-1:0]    pos_x;
   logic signed [uvs_pkg::POS_W-1:0]    pos_y;
   logic signed [uvs_pkg::POS_W-1:0]    pos_z;
   logic signed [uvs_pkg::NORM_W-1:0]   norm_x;
   logic signed [uvs_pkg::NORM_W-1:0]   norm_y;
   logic signed [uvs_pkg::NORM_W-1:0]   norm_z;
   logic [uvs_pkg::TEX_W-1:0]           tex_u;
   logic [uvs_pkg::TEX_W-1:0]           tex_v;
   logic [uvs_pkg::CORNER_W-1:0]        first_corner;
   logic [uvs_pkg::CORNER_W-1:0]        second_corner;
   logic                                quad_start;
   logic                                index_error;

   modport source (output valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_u, tex_v,
                   first_corner, second_corner, quad_start, index_error, input ready);
   modport sink   (input valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_u, tex_v,
                   first_corner, second_corner, quad_start, index_error, output ready);
endinterface

// ----- rtl/core/uvs_csr_if.sv -----
// register write channel
interface uvs_csr_if;
   logic                           valid;
   logic                           ready;
   logic [uvs_pkg::CSR_IDX_W-1:0]  index;
   logic [uvs_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/core/uvs_divider.sv -----
// pipelined restoring divider, one quotient bit per stage
module uvs_divider #(
   parameter int NUM_W = 27,
   parameter int DEN_W = 10,
   parameter int QUO_W = 17
) (
   input  logic             clock,
   input  logic             adv,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [QUO_W-1:0] quo
);
   logic [DEN_W-1:0] rem_ff  [QUO_W];
   logic [DEN_W-1:0] rem_in  [QUO_W];
   logic [QUO_W-1:0] bits_ff [QUO_W];
   logic [QUO_W-1:0] bits_in [QUO_W];
   logic [QUO_W-1:0] quo_ff  [QUO_W];
   logic [QUO_W-1:0] quo_in  [QUO_W];

   // each stage shifts in one numerator bit and tries a subtract
   always_comb begin
      logic [DEN_W-1:0] r;
      logic [QUO_W-1:0] bts;
      logic [QUO_W-1:0] q;
      logic [DEN_W:0]   trial;
      logic             ge;
      for (int k = 0; k < QUO_W; k++) begin
         if (k == 0) begin
            r   = DEN_W'(num >> QUO_W);
            bts = num[QUO_W-1:0];
            q   = '0;
         end else begin
            r   = rem_ff[k-1];
            bts = bits_ff[k-1];
            q   = quo_ff[k-1];
         end
         trial      = {r, bts[QUO_W-1]};
         ge         = trial >= {1'b0, den};
         rem_in[k]  = ge ? DEN_W'(trial - {1'b0, den}) : DEN_W'(trial);
         bits_in[k] = bts << 1;
         quo_in[k]  = {q[QUO_W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < QUO_W; k++) begin
            rem_ff[k]  <= rem_in[k];
            bits_ff[k] <= bits_in[k];
            quo_ff[k]  <= quo_in[k];
         end
      end
   end

   assign quo = quo_ff[QUO_W-1];
endmodule

// ----- rtl/core/uvs_sincos.sv -----
// seven stage sine and cosine of a phase by octant folding and taylor series
module uvs_sincos #(
   parameter int ANGLE_BITS = 16
) (
   input  logic                   clock,
   input  logic                   adv,
   input  logic [ANGLE_BITS-1:0]  phase,
   output uvs_pkg::sincos_type    sc
);
   import uvs_pkg::*;

   localparam int NSTG = 7;
   localparam int PW   = ANGLE_BITS + 30;

   logic [1:0]       quad_ff [NSTG-1];
   logic             swap_ff [NSTG-1];
   logic [Q30_W-1:0] x1_ff, x2_ff, x3_ff, x4_ff, x5_ff;
   logic [Q30_W-1:0] p2_ff, p2b_ff, p2c_ff, p2d_ff;
   logic [Q30_W-1:0] p3_ff, p3b_ff, p4_ff, p4b_ff;
   logic [Q30_W-1:0] p5_ff, p6_ff, p8_ff, p5b_ff;
   logic [Q30_W-1:0] p3c_ff, p4c_ff, p6b_ff, p8b_ff;
   logic [Q30_W-1:0] p7_ff, p9_ff, p10_ff;
   logic [Q30_W-1:0] t1_ff, t2_ff, t3_ff, t4_ff, t5_ff, t6_ff, t7_ff, t8_ff, t9_ff, t10_ff;
   sincos_type       sc_ff;

   logic [1:0]            quad_in;
   logic                  swap_in;
   logic [ANGLE_BITS-3:0] a_w;
   logic [ANGLE_BITS-2:0] bw_w;
   logic [ANGLE_BITS-3:0] b_w;
   logic [PW-1:0]         xprod_w;
   logic [SC_W-1:0]       sn_w, cs_w;
   logic signed [SC_W-1:0] s0_w, c0_w;
   sincos_type            sc_in;

   // octant fold and scale to radians in q30
   assign quad_in = phase[ANGLE_BITS-1:ANGLE_BITS-2];
   assign a_w     = phase[ANGLE_BITS-3:0];
   assign swap_in = a_w > (ANGLE_BITS-2)'(1 << (ANGLE_BITS-3));
   assign bw_w    = swap_in ? (ANGLE_BITS-1)'(1 << (ANGLE_BITS-2)) - (ANGLE_BITS-1)'(a_w)
                            : (ANGLE_BITS-1)'(a_w);
   assign b_w     = bw_w[ANGLE_BITS-3:0];
   assign xprod_w = PW'(b_w) * PW'(PI_Q30) + (PW'(1) << (ANGLE_BITS-2));

   // series sums, fold back and quadrant signs
   assign sn_w = SC_W'(t1_ff) + SC_W'(t5_ff) + SC_W'(t9_ff) - SC_W'(t3_ff) - SC_W'(t7_ff);
   assign cs_w = (SC_W'(1) << Q30_W) + SC_W'(t4_ff) + SC_W'(t8_ff)
               - SC_W'(t2_ff) - SC_W'(t6_ff) - SC_W'(t10_ff);
   assign s0_w = swap_ff[NSTG-2] ? signed'(cs_w) : signed'(sn_w);
   assign c0_w = swap_ff[NSTG-2] ? signed'(sn_w) : signed'(cs_w);

   always_comb begin
      unique case (quad_ff[NSTG-2])
         2'd0: begin
            sc_in.s = s0_w;
            sc_in.c = c0_w;
         end
         2'd1: begin
            sc_in.s = c0_w;
            sc_in.c = -s0_w;
         end
         2'd2: begin
            sc_in.s = -s0_w;
            sc_in.c = -c0_w;
         end
         default: begin
            sc_in.s = -c0_w;
            sc_in.c = s0_w;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         // quadrant and fold flags ride along
         quad_ff[0] <= quad_in;
         swap_ff[0] <= swap_in;
         for (int k = 1; k < NSTG-1; k++) begin
            quad_ff[k] <= quad_ff[k-1];
            swap_ff[k] <= swap_ff[k-1];
         end
         // stage 1: angle
         x1_ff  <= Q30_W'(xprod_w >> (ANGLE_BITS-1));
         // stage 2: square
         x2_ff  <= x1_ff;
         p2_ff  <= qmul(x1_ff, x1_ff);
         // stage 3: cube and fourth power
         x3_ff  <= x2_ff;
         p2b_ff <= p2_ff;
         p3_ff  <= qmul(p2_ff, x2_ff);
         p4_ff  <= qmul(p2_ff, p2_ff);
         // stage 4: fifth, sixth, eighth
         x4_ff  <= x3_ff;
         p2c_ff <= p2b_ff;
         p3b_ff <= p3_ff;
         p4b_ff <= p4_ff;
         p5_ff  <= qmul(p4_ff, x3_ff);
         p6_ff  <= qmul(p4_ff, p2b_ff);
         p8_ff  <= qmul(p4_ff, p4_ff);
         // stage 5: seventh, ninth, tenth
         x5_ff  <= x4_ff;
         p2d_ff <= p2c_ff;
         p5b_ff <= p5_ff;
         p3c_ff <= p3b_ff;
         p4c_ff <= p4b_ff;
         p6b_ff <= p6_ff;
         p8b_ff <= p8_ff;
         p7_ff  <= qmul(p6_ff, x4_ff);
         p9_ff  <= qmul(p8_ff, x4_ff);
         p10_ff <= qmul(p8_ff, p2c_ff);
         // stage 6: series terms
         t1_ff  <= x5_ff;
         t2_ff  <= p2d_ff >> 1;
         t3_ff  <= div_recip(p3c_ff, R6, S6);
         t4_ff  <= div_recip(p4c_ff, R24, S24);
         t5_ff  <= div_recip(p5b_ff, R120, S120);
         t6_ff  <= div_recip(p6b_ff, R720, S720);
         t7_ff  <= div_recip(p7_ff, R5040, S5040);
         t8_ff  <= div_recip(p8b_ff, R40320, S40320);
         t9_ff  <= div_recip(p9_ff, R362880, S362880);
         t10_ff <= div_recip(p10_ff, R3628800, S3628800);
         // stage 7: result
         sc_ff  <= sc_in;
      end
   end

   assign sc = sc_ff;
endmodule

// ----- rtl/core/uvs_delay.sv -----
// stalling shift line for data that rides beside the arithmetic
module uvs_delay #(
   parameter int W     = 8,
   parameter int DEPTH = 2
) (
   input  logic         clock,
   input  logic         adv,
   input  logic [W-1:0] din,
   output logic [W-1:0] dout
);
   logic [W-1:0] data_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (adv) begin
         data_ff[0] <= din;
         for (int k = 1; k < DEPTH; k++) begin
            data_ff[k] <= data_ff[k-1];
         end
      end
   end

   assign dout = data_ff[DEPTH-1];
endmodule

// ----- rtl/core/uvs_vertex.sv -----
// two stage normal rounding and radius scaling
module uvs_vertex (
   input  logic                             clock,
   input  logic                             adv,
   input  logic [uvs_pkg::RADIUS_W-1:0]     radius,
   input  uvs_pkg::sincos_type              theta,
   input  uvs_pkg::sincos_type              phi,
   output uvs_pkg::vertex_type              vtx
);
   import uvs_pkg::*;

   logic [MAG_W-1:0] mx_ff, my_ff, mz_ff;
   logic             nx_ff, ny_ff, nz_ff;
   vertex_type       vtx_ff;

   logic [SC_W-2:0]     ast_w, act_w, acp_w, asp_w;
   logic [2*SC_W-3:0]   px_w, pz_w;
   logic [SC_W-1:0]     py_w;
   vertex_type          vtx_in;

   // magnitudes of the q30 terms
   assign ast_w = theta.s[SC_W-1] ? (SC_W-1)'(-theta.s) : (SC_W-1)'(theta.s);
   assign act_w = theta.c[SC_W-1] ? (SC_W-1)'(-theta.c) : (SC_W-1)'(theta.c);
   assign acp_w = phi.c[SC_W-1]   ? (SC_W-1)'(-phi.c)   : (SC_W-1)'(phi.c);
   assign asp_w = phi.s[SC_W-1]   ? (SC_W-1)'(-phi.s)   : (SC_W-1)'(phi.s);

   // q30 by q30 to q15, half away from zero
   assign px_w = (2*SC_W-2)'(acp_w) * (2*SC_W-2)'(ast_w) + ((2*SC_W-2)'(1) << 44);
   assign pz_w = (2*SC_W-2)'(asp_w) * (2*SC_W-2)'(ast_w) + ((2*SC_W-2)'(1) << 44);
   assign py_w = SC_W'(act_w) + (SC_W'(1) << 14);

   function automatic logic signed [NORM_W-1:0] sat_norm(input logic [MAG_W-1:0] m,
                                                        input logic neg);
      logic signed [NORM_W-1:0] r;
      if (neg) begin
         r = NORM_W'(-{1'b0, m});
      end else if (m > MAG_W'(32767)) begin
         r = NORM_W'(32767);
      end else begin
         r = NORM_W'(m);
      end
      return r;
   endfunction

   function automatic logic signed [POS_W-1:0] scale(input logic [RADIUS_W-1:0] rad,
                                                     input logic [MAG_W-1:0] m,
                                                     input logic neg);
      logic [RADIUS_W+MAG_W-1:0] p;
      logic [POS_W-1:0]          q;
      p = (RADIUS_W+MAG_W)'(rad) * (RADIUS_W+MAG_W)'(m) + (RADIUS_W+MAG_W)'(1 << 14);
      q = POS_W'(p >> 15);
      return neg ? -signed'(q) : signed'(q);
   endfunction

   always_comb begin
      vtx_in.norm_x = sat_norm(mx_ff, nx_ff);
      vtx_in.norm_y = sat_norm(my_ff, ny_ff);
      vtx_in.norm_z = sat_norm(mz_ff, nz_ff);
      vtx_in.pos_x  = scale(radius, mx_ff, nx_ff);
      vtx_in.pos_y  = scale(radius, my_ff, ny_ff);
      vtx_in.pos_z  = scale(radius, mz_ff, nz_ff);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mx_ff  <= MAG_W'(px_w >> 45);
         mz_ff  <= MAG_W'(pz_w >> 45);
         my_ff  <= MAG_W'(py_w >> 15);
         nx_ff  <= phi.c[SC_W-1] ^ theta.s[SC_W-1];
         nz_ff  <= phi.s[SC_W-1] ^ theta.s[SC_W-1];
         ny_ff  <= theta.c[SC_W-1];
         vtx_ff <= vtx_in;
      end
   end

   assign vtx = vtx_ff;
endmodule

// ----- rtl/core/uv_sphere_vertex_generator_unit.sv -----
// the path from accept to result runs through the one-bit-per-stage phase dividers
// (max(ANGLE_BITS+1,17) stages), seven sine/cosine stages and two normal/position stages
// throughput: one item per cycle; the whole pipeline holds while a result is not taken
// reset clears every valid bit and loads radius 1.0, 16 latitude and 16 longitude bands
module uv_sphere_vertex_generator_unit #(
   parameter int ANGLE_BITS = uvs_pkg::ANGLE_BITS_DEF
) (
   input  logic  clock,
   input  logic  reset,
   uvs_req_if.sink   req_ch,
   uvs_rsp_if.source rsp_ch,
   uvs_csr_if.sink   csr_ch
);
   import uvs_pkg::*;

   localparam int QUO_W  = (ANGLE_BITS + 1 > TEX_W) ? ANGLE_BITS + 1 : TEX_W;
   localparam int NUM_W  = (ANGLE_BITS + 11 > TEX_W + 10) ? ANGLE_BITS + 11 : TEX_W + 10;
   localparam int DEPTH  = QUO_W + 9;
   localparam int SIDE_W = 2*CORNER_W + 2;

   logic [RADIUS_W-1:0] radius_ff;
   logic [IDX_W-1:0]    lat_bands_ff, lon_bands_ff;
   logic [DEPTH-1:0]    vld_ff;
   logic                adv;

   logic [NUM_W-1:0]    num_t, num_p, num_u, num_v;
   logic [QUO_W-1:0]    quo_t, quo_p, quo_u, quo_v;
   logic [CORNER_W+2:0] first_w;
   logic [CORNER_W-1:0] first_c, second_c, first_o, second_o;
   logic                quad_w, err_w, quad_o, err_o;
   logic [TEX_W-1:0]    tex_u_o, tex_v_o;
   sincos_type          sc_theta, sc_phi;
   vertex_type          vtx;

   // register writes
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff    <= RADIUS_RST;
         lat_bands_ff <= BANDS_RST;
         lon_bands_ff <= BANDS_RST;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_RADIUS:    radius_ff    <= csr_ch.data[RADIUS_W-1:0];
            CSR_LAT_BANDS: lat_bands_ff <= csr_ch.data[IDX_W-1:0];
            CSR_LON_BANDS: lon_bands_ff <= csr_ch.data[IDX_W-1:0];
            default: ;
         endcase
      end
   end

   // pipeline advance and valid bits
   assign adv          = !vld_ff[DEPTH-1] || rsp_ch.ready;
   assign req_ch.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[DEPTH-2:0], req_ch.valid};
      end
   end

   // dividend for each rounded quotient
   assign num_t = (NUM_W'(req_ch.lat_index) << ANGLE_BITS) + NUM_W'(lat_bands_ff);
   assign num_p = (NUM_W'(req_ch.lon_index) << (ANGLE_BITS + 1)) + NUM_W'(lon_bands_ff);
   assign num_u = (NUM_W'(IDX_W'(lon_bands_ff - req_ch.lon_index)) << TEX_W)
                + NUM_W'(lon_bands_ff);
   assign num_v = (NUM_W'(req_ch.lat_index) << TEX_W) + NUM_W'(lat_bands_ff);

   uvs_divider #(.NUM_W(NUM_W), .DEN_W(DEN_W), .QUO_W(QUO_W)) u_div_t (
      .clock(clock), .adv(adv), .num(num_t), .den({lat_bands_ff, 1'b0}), .quo(quo_t));
   uvs_divider #(.NUM_W(NUM_W), .DEN_W(DEN_W), .QUO_W(QUO_W)) u_div_p (
      .clock(clock), .adv(adv), .num(num_p), .den({lon_bands_ff, 1'b0}), .quo(quo_p));
   uvs_divider #(.NUM_W(NUM_W), .DEN_W(DEN_W), .QUO_W(QUO_W)) u_div_u (
      .clock(clock), .adv(adv), .num(num_u), .den({lon_bands_ff, 1'b0}), .quo(quo_u));
   uvs_divider #(.NUM_W(NUM_W), .DEN_W(DEN_W), .QUO_W(QUO_W)) u_div_v (
      .clock(clock), .adv(adv), .num(num_v), .den({lat_bands_ff, 1'b0}), .quo(quo_v));

   // sine and cosine of both angles
   uvs_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sc_theta (
      .clock(clock), .adv(adv), .phase(quo_t[ANGLE_BITS-1:0]), .sc(sc_theta));
   uvs_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sc_phi (
      .clock(clock), .adv(adv), .phase(quo_p[ANGLE_BITS-1:0]), .sc(sc_phi));

   uvs_vertex u_vertex (
      .clock(clock), .adv(adv), .radius(radius_ff), .theta(sc_theta), .phi(sc_phi),
      .vtx(vtx));

   // texture coordinates wait for the trig and vertex stages
   uvs_delay #(.W(2*TEX_W), .DEPTH(9)) u_tex_dly (
      .clock(clock), .adv(adv),
      .din({quo_u[TEX_W-1:0], quo_v[TEX_W-1:0]}),
      .dout({tex_u_o, tex_v_o}));

   // corners and flags
   assign first_w  = (CORNER_W+3)'(req_ch.lat_index) * (CORNER_W+3)'({1'b0, lon_bands_ff} + 10'd1)
                   + (CORNER_W+3)'(req_ch.lon_index);
   assign first_c  = first_w[CORNER_W-1:0];
   assign second_c = first_c + CORNER_W'(lon_bands_ff) + CORNER_W'(1);
   assign quad_w   = (req_ch.lat_index < lat_bands_ff) && (req_ch.lon_index < lon_bands_ff);
   assign err_w    = (lat_bands_ff == '0) || (lon_bands_ff == '0)
                  || (32'(lat_bands_ff) > MAX_BANDS) || (32'(lon_bands_ff) > MAX_BANDS)
                  || (req_ch.lat_index > lat_bands_ff) || (req_ch.lon_index > lon_bands_ff);

   uvs_delay #(.W(SIDE_W), .DEPTH(DEPTH)) u_side_dly (
      .clock(clock), .adv(adv),
      .din({first_c, second_c, quad_w, err_w}),
      .dout({first_o, second_o, quad_o, err_o}));

   // result, zeroed on an index error
   assign rsp_ch.valid         = vld_ff[DEPTH-1];
   assign rsp_ch.index_error   = err_o;
   assign rsp_ch.pos_x         = err_o ? '0 : vtx.pos_x;
   assign rsp_ch.pos_y         = err_o ? '0 : vtx.pos_y;
   assign rsp_ch.pos_z         = err_o ? '0 : vtx.pos_z;
   assign rsp_ch.norm_x        = err_o ? '0 : vtx.norm_x;
   assign rsp_ch.norm_y        = err_o ? '0 : vtx.norm_y;
   assign rsp_ch.norm_z        = err_o ? '0 : vtx.norm_z;
   assign rsp_ch.tex_u         = err_o ? '0 : tex_u_o;
   assign rsp_ch.tex_v         = err_o ? '0 : tex_v_o;
   assign rsp_ch.first_corner  = err_o ? '0 : first_o;
   assign rsp_ch.second_corner = err_o ? '0 : second_o;
   assign rsp_ch.quad_start    = err_o ? 1'b0 : quad_o;

   // checks
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_ch.valid)
      else $error("result valid right after reset");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> vld_ff[0])
      else $error("accepted item did not enter the pipeline");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !adv |=> vld_ff == $past(vld_ff))
      else $error("valid bits moved during a stall");

   a_error_no_quad: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.index_error |-> !rsp_ch.quad_start && rsp_ch.tex_v == '0)
      else $error("error result carries data");

   a_corner_step: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.index_error |->
         rsp_ch.second_corner == rsp_ch.first_corner + CORNER_W'(lon_bands_ff) + CORNER_W'(1))
      else $error("corner indices out of step");
endmodule
